// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the frame allocator rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// temporal property checked at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_PROP(lbl, clk, rst, prop, msg)

`endif

`endif

// ===== hw/rtl/otfa_pkg.sv =====
// shared types, codes and default sizes for the owner tagged frame allocator
// no dependencies; imported by every module of the block
package otfa_pkg;

   // field widths of the transaction payloads
   localparam int OPCODE_W = 2;
   localparam int OWNER_W  = 8;
   localparam int FRAMES_W = 7;
   localparam int STATUS_W = 2;
   localparam int FIRST_W  = 6;
   localparam int TOTAL_W  = 32;

   // default sizes
   localparam int NUM_FRAMES_DEF  = 64;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int OWNER_BITS_DEF  = 8;

   // request opcodes
   localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_STATUS  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FRAMES  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [OWNER_W-1:0]  owner_id;
      logic [FRAMES_W-1:0] frames_wanted;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIRST_W-1:0]  first_frame;
      logic [FRAMES_W-1:0] free_frames;
      logic                owner_present;
      logic [FRAMES_W-1:0] owner_frames;
      logic                oldest_valid;
      logic [OWNER_W-1:0]  oldest_owner;
      logic [TOTAL_W-1:0]  paged_in_total;
      logic [TOTAL_W-1:0]  paged_out_total;
   } rsp_type;

   // controls broadcast to every frame cell
   typedef struct packed {
      logic wr;     // tag the addressed frame with the write owner
      logic load;   // capture owner match into the hit chain
      logic clear;  // with load: drop the tags that match
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/otfa_cell.sv =====
// one frame cell: owner tag of a single frame plus one stage of the hit chain
// depends on otfa_pkg
module otfa_cell
   import otfa_pkg::*;
#(
   parameter int OWNER_BITS = OWNER_BITS_DEF,
   parameter int FW         = 6,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [FW-1:0]         wr_frame,
   input  logic [OWNER_BITS-1:0] wr_owner,
   input  logic [OWNER_BITS-1:0] cmp_owner,
   input  logic                  hit_in,
   output logic                  hit_out
);

   logic                  tag_valid_ff;
   logic [OWNER_BITS-1:0] tag_owner_ff;
   logic                  hit_ff;
   logic                  match;
   logic                  selected;

   assign match    = tag_valid_ff && (tag_owner_ff == cmp_owner);
   assign selected = ctrl.wr && (wr_frame == FW'(INDEX));

   // owner tag
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
      end else if (selected) begin
         tag_valid_ff <= 1'b1;
      end else if (ctrl.load && ctrl.clear && match) begin
         tag_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (selected) begin
         tag_owner_ff <= wr_owner;
      end
   end

   // hit chain stage: load on scan start, otherwise shift toward frame zero
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctrl.load) begin
         hit_ff <= match;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit_out = hit_ff;

endmodule

// ===== hw/rtl/otfa_stack.sv =====
// free frame stack memory with a low-water mark standing in for the reset fill
// depends on otfa_pkg
module otfa_stack
   import otfa_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF,
   parameter int FW         = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [FW-1:0] rd_addr,
   output logic [FW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [FW-1:0] wr_addr,
   input  logic [FW-1:0] wr_data
);

   localparam int CW = $clog2(NUM_FRAMES + 1);

   logic [FW-1:0] stack_mem [NUM_FRAMES];
   logic [FW-1:0] rd_mem_ff;
   logic [FW-1:0] rd_addr_ff;
   logic          rd_init_ff;
   logic [CW-1:0] low_water_ff;
   logic          below_mark;

   // an entry below every depth reached so far was never pushed: it holds its index
   assign below_mark = CW'(rd_addr) < low_water_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mem_ff  <= stack_mem[rd_addr];
         rd_addr_ff <= rd_addr;
         rd_init_ff <= below_mark;
      end
   end

   // lowest stack depth ever popped
   always_ff @(posedge clock) begin
      if (reset) begin
         low_water_ff <= CW'(NUM_FRAMES);
      end else if (rd_en && below_mark) begin
         low_water_ff <= CW'(rd_addr);
      end
   end

   assign rd_data = rd_init_ff ? rd_addr_ff : rd_mem_ff;

endmodule

// ===== hw/rtl/owner_tagged_frame_allocator.sv =====
// top level of the owner tagged frame allocator: sequencer, owner queue, cell row
// depends on otfa_pkg, otfa_cell, otfa_stack and assert_macros.svh
//
// Usage: a request transaction on req_* carries an opcode (allocate, release,
// status), an owner id and a frame count. Each request yields exactly one
// response transaction on rsp_* with the status, the first frame granted, the
// free frame count, the owner's holdings, the oldest queued owner and the two
// saturating page counters. Both channels use valid and stall.
// Frame tags live in a row of cells; every request ends with one pass that
// shifts the owner-match bits out of the row, one frame per cycle in ascending
// order, and a granted allocation first pops its frames off the free stack
// memory one by one, each through a read state and a tag state around its
// registered read. One request is in service at a time; req_stall is high
// while it is, so the next request is taken only after the response of the
// current one has been loaded into the output register.
// A response waiting on rsp_stall does not block the next request, which is
// taken at once; its own response is held until the output register is free.
// Reset: synchronous, active high; all frames free with the stack holding
// frame numbers in ascending order, the queue empty and the counters at zero.
// No clearing pass is needed after reset.
`include "assert_macros.svh"

module owner_tagged_frame_allocator
   import otfa_pkg::*;
#(
   parameter int NUM_FRAMES  = NUM_FRAMES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int OWNER_BITS  = OWNER_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int FW   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CW   = $clog2(NUM_FRAMES + 1);
   localparam int QAW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
   localparam int OUSE = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;
   localparam int WCW  = (CW > FRAMES_W) ? CW : FRAMES_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_ALLOC_RD,
      S_ALLOC_WR,
      S_SCAN_LOAD,
      S_SCAN,
      S_RESPOND
   } state_type;

   state_type             state_ff;
   logic [OPCODE_W-1:0]   op_ff;
   logic [OWNER_BITS-1:0] owner_ff;
   logic [FRAMES_W-1:0]   wanted_ff;
   logic [FRAMES_W-1:0]   remaining_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic [FW-1:0]         first_ff;
   logic                  first_pending_ff;
   logic [CW-1:0]         free_count_ff;
   logic [CW-1:0]         held_ff;
   logic [FW-1:0]         step_ff;
   logic [QAW-1:0]        head_ff;
   logic [QCW-1:0]        queue_count_ff;
   logic [TOTAL_W-1:0]    pages_in_ff;
   logic [TOTAL_W-1:0]    pages_out_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [OWNER_BITS-1:0] queue_mem [QUEUE_DEPTH];
   logic [OWNER_BITS-1:0] q_head_ff;

   logic                  req_take;
   logic                  no_frames;
   logic                  q_full;
   logic                  grant;
   logic [STATUS_W-1:0]   decide_status;
   logic                  q_wr_en;
   logic [QAW:0]          tail_sum;
   logic [QAW-1:0]        tail_idx;
   logic [QAW-1:0]        head_next;
   logic [TOTAL_W:0]      pages_in_sum;
   logic                  is_release;
   logic                  last_step;
   logic                  out_free;

   cell_ctrl_type         cell_ctrl;
   logic [NUM_FRAMES:0]   hit_link;
   logic                  stk_rd_en;
   logic [FW-1:0]         stk_rd_addr;
   logic [FW-1:0]         stk_rd_data;
   logic                  stk_wr_en;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // allocation decision
   assign no_frames = WCW'(wanted_ff) > WCW'(free_count_ff);
   assign q_full    = queue_count_ff >= QCW'(QUEUE_DEPTH);
   assign grant     = (op_ff == OP_ALLOC) && !no_frames && !q_full;
   assign q_wr_en   = (state_ff == S_DECIDE) && grant;
   assign is_release = (op_ff == OP_RELEASE);

   // refusal order: too few frames first, then a full queue
   assign decide_status = (op_ff != OP_ALLOC) ? ST_DONE
                        : no_frames ? ST_NO_FRAMES
                        : q_full ? ST_QUEUE_FULL : ST_DONE;

   // queue tail and head wrap for any depth
   assign tail_sum  = (QAW+1)'(head_ff) + (QAW+1)'(queue_count_ff);
   assign tail_idx  = (tail_sum >= (QAW+1)'(QUEUE_DEPTH))
                      ? QAW'(tail_sum - (QAW+1)'(QUEUE_DEPTH)) : QAW'(tail_sum);
   assign head_next = (head_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign pages_in_sum = {1'b0, pages_in_ff} + (TOTAL_W+1)'(wanted_ff);
   assign last_step    = (step_ff == FW'(NUM_FRAMES - 1));

   // owner queue memory, head read registered every cycle
   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         queue_mem[tail_idx] <= owner_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_head_ff <= queue_mem[head_ff];
   end

   // free stack ports
   assign stk_rd_en   = (state_ff == S_ALLOC_RD);
   assign stk_rd_addr = FW'(free_count_ff - 1'b1);
   assign stk_wr_en   = (state_ff == S_SCAN) && is_release && hit_link[0]
                        && (free_count_ff < CW'(NUM_FRAMES));

   otfa_stack #(
      .NUM_FRAMES (NUM_FRAMES),
      .FW         (FW)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data),
      .wr_en   (stk_wr_en),
      .wr_addr (FW'(free_count_ff)),
      .wr_data (step_ff)
   );

   // row of frame cells; hit bits shift toward frame zero
   always_comb begin
      cell_ctrl.wr    = (state_ff == S_ALLOC_WR);
      cell_ctrl.load  = (state_ff == S_SCAN_LOAD);
      cell_ctrl.clear = is_release;
   end

   assign hit_link[NUM_FRAMES] = 1'b0;

   for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
      otfa_cell #(
         .OWNER_BITS (OWNER_BITS),
         .FW         (FW),
         .INDEX      (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .wr_frame  (stk_rd_data),
         .wr_owner  (owner_ff),
         .cmp_owner (owner_ff),
         .hit_in    (hit_link[k+1]),
         .hit_out   (hit_link[k])
      );
   end

   // sequencer with its registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         free_count_ff    <= CW'(NUM_FRAMES);
         head_ff          <= '0;
         queue_count_ff   <= '0;
         pages_in_ff      <= '0;
         pages_out_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
         first_pending_ff <= 1'b0;
      end else begin
         // output register: loaded when the response is built, freed when taken
         if ((state_ff == S_RESPOND) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  op_ff     <= req_data.opcode;
                  owner_ff  <= OWNER_BITS'(req_data.owner_id[OUSE-1:0]);
                  wanted_ff <= req_data.frames_wanted;
                  state_ff  <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               status_ff        <= decide_status;
               first_ff         <= '0;
               first_pending_ff <= grant;
               state_ff         <= (grant && (wanted_ff != '0)) ? S_ALLOC_RD
                                                                 : S_SCAN_LOAD;
               case (op_ff)
                  OP_ALLOC: begin
                     if (grant) begin
                        pages_in_ff    <= pages_in_sum[TOTAL_W] ? '1
                                          : pages_in_sum[TOTAL_W-1:0];
                        queue_count_ff <= queue_count_ff + 1'b1;
                        remaining_ff   <= wanted_ff;
                     end
                  end
                  OP_RELEASE: begin
                     if (queue_count_ff != '0) begin
                        head_ff        <= head_next;
                        queue_count_ff <= queue_count_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            // pop one frame: read the stack top
            S_ALLOC_RD: begin
               free_count_ff <= free_count_ff - 1'b1;
               remaining_ff  <= remaining_ff - 1'b1;
               state_ff      <= S_ALLOC_WR;
            end
            // popped frame arrives: tag it
            S_ALLOC_WR: begin
               if (first_pending_ff) begin
                  first_ff         <= stk_rd_data;
                  first_pending_ff <= 1'b0;
               end
               state_ff <= (remaining_ff == '0) ? S_SCAN_LOAD : S_ALLOC_RD;
            end
            S_SCAN_LOAD: begin
               held_ff  <= '0;
               step_ff  <= '0;
               state_ff <= S_SCAN;
            end
            // one frame per cycle, ascending
            S_SCAN: begin
               if (hit_link[0]) begin
                  if (is_release) begin
                     if (pages_out_ff != '1) begin
                        pages_out_ff <= pages_out_ff + 1'b1;
                     end
                     if (free_count_ff < CW'(NUM_FRAMES)) begin
                        free_count_ff <= free_count_ff + 1'b1;
                     end
                  end else begin
                     held_ff <= held_ff + 1'b1;
                  end
               end
               step_ff <= step_ff + 1'b1;
               if (last_step) begin
                  state_ff <= S_RESPOND;
               end
            end
            S_RESPOND: begin
               if (out_free) begin
                  rsp_ff.status          <= status_ff;
                  rsp_ff.first_frame     <= FIRST_W'(first_ff);
                  rsp_ff.free_frames     <= FRAMES_W'(free_count_ff);
                  rsp_ff.owner_present   <= (held_ff != '0);
                  rsp_ff.owner_frames    <= FRAMES_W'(held_ff);
                  rsp_ff.oldest_valid    <= (queue_count_ff != '0);
                  rsp_ff.oldest_owner    <= (queue_count_ff != '0)
                                            ? OWNER_W'(q_head_ff) : '0;
                  rsp_ff.paged_in_total  <= pages_in_ff;
                  rsp_ff.paged_out_total <= pages_out_ff;
                  state_ff               <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `ASSERT_ALWAYS(a_free_range, clock, reset, free_count_ff <= CW'(NUM_FRAMES), "free count high")
   `ASSERT_ALWAYS(a_queue_range, clock, reset, queue_count_ff <= QCW'(QUEUE_DEPTH), "queue overfull")
   `ASSERT_ALWAYS(a_pop_nonempty, clock, reset, (state_ff != S_ALLOC_RD) || (free_count_ff != '0), "empty pop")
   `ASSERT_PROP(a_pages_in_mono, clock, reset, 1'b1 |=> (pages_in_ff >= $past(pages_in_ff)), "paged in fell")

endmodule

// ===== tb/otfa_checker.sv =====
// transaction checker for the owner tagged frame allocator: predicts each response
// from accepted requests and compares it field by field; depends on otfa_pkg
`timescale 1ns / 100ps

module otfa_checker
   import otfa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      outstanding
);

   localparam int NF      = NUM_FRAMES_DEF;
   localparam int QD      = QUEUE_DEPTH_DEF;
   localparam int FRAME_W = $clog2(NF);
   localparam int QPTR_W  = $clog2(QD);

   // predicted pool state
   logic [FRAME_W-1:0] free_list [NF];
   logic [FRAMES_W:0]  free_total;
   logic               tag_valid [NF];
   logic [OWNER_W-1:0] tag_owner [NF];
   logic [OWNER_W-1:0] grant_fifo [QD];
   logic [QPTR_W-1:0]  fifo_head;
   int                 fifo_fill;
   logic [TOTAL_W-1:0] in_total;
   logic [TOTAL_W-1:0] out_total;

   rsp_type pool_rsp_q [$];
   int      mismatches;
   int      rsp_index;

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                  input logic [TOTAL_W-1:0] b);
      logic [TOTAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
   endfunction

   // advance the predicted pool by one request and build its response
   function automatic rsp_type apply_pool_request(input req_type r);
      rsp_type            o;
      int                 i;
      int                 f;
      int                 held;
      logic [FRAME_W-1:0] fr;
      o = '0;
      held = 0;
      case (r.opcode)
         OP_ALLOC: begin
            if (r.frames_wanted > free_total) begin
               o.status = ST_NO_FRAMES;
            end else if (fifo_fill >= QD) begin
               o.status = ST_QUEUE_FULL;
            end else begin
               o.status = ST_DONE;
               // each frame comes off the top of the free list on its own
               for (i = 0; i < r.frames_wanted; i++) begin
                  free_total = free_total - 1'b1;
                  fr = free_list[FRAME_W'(free_total)];
                  if (i == 0) o.first_frame = fr;
                  tag_valid[fr] = 1'b1;
                  tag_owner[fr] = r.owner_id;
               end
               in_total = sat_add(in_total, TOTAL_W'(r.frames_wanted));
               grant_fifo[QPTR_W'(fifo_head + fifo_fill)] = r.owner_id;
               fifo_fill++;
            end
         end
         OP_RELEASE: begin
            // free the owner's frames in ascending order
            for (f = 0; f < NF; f++) begin
               if (tag_valid[f] && tag_owner[f] == r.owner_id) begin
                  tag_valid[f] = 1'b0;
                  if (free_total < NF) begin
                     free_list[FRAME_W'(free_total)] = FRAME_W'(f);
                     free_total = free_total + 1'b1;
                  end
                  out_total = sat_add(out_total, TOTAL_W'(1));
               end
            end
            if (fifo_fill > 0) begin
               fifo_head = fifo_head + 1'b1;
               fifo_fill--;
            end
         end
         default: begin
            // status and the unused opcode change nothing
         end
      endcase
      for (f = 0; f < NF; f++)
         if (tag_valid[f] && tag_owner[f] == r.owner_id) held++;
      o.free_frames     = FRAMES_W'(free_total);
      o.owner_present   = (held != 0);
      o.owner_frames    = FRAMES_W'(held);
      o.oldest_valid    = (fifo_fill != 0);
      o.oldest_owner    = (fifo_fill != 0) ? grant_fifo[fifo_head] : '0;
      o.paged_in_total  = in_total;
      o.paged_out_total = out_total;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [TOTAL_W-1:0] got,
                              input logic [TOTAL_W-1:0] want);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response %0d: %s expected %0h, got %0h", rsp_index, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int f = 0; f < NF; f++) begin
            free_list[f] = FRAME_W'(f);
            tag_valid[f] = 1'b0;
            tag_owner[f] = '0;
         end
         free_total = (FRAMES_W+1)'(NF);
         fifo_head  = '0;
         fifo_fill  = 0;
         in_total   = '0;
         out_total  = '0;
         pool_rsp_q.delete();
         mismatches = 0;
         rsp_index  = 0;
      end else begin
         // compare a response transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pool_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d arrived with no request waiting: %h",
                           rsp_index, rsp_data);
            end else begin
               want = pool_rsp_q.pop_front();
               check_field("status", TOTAL_W'(rsp_data.status), TOTAL_W'(want.status));
               check_field("first_frame", TOTAL_W'(rsp_data.first_frame),
                           TOTAL_W'(want.first_frame));
               check_field("free_frames", TOTAL_W'(rsp_data.free_frames),
                           TOTAL_W'(want.free_frames));
               check_field("owner_present", TOTAL_W'(rsp_data.owner_present),
                           TOTAL_W'(want.owner_present));
               check_field("owner_frames", TOTAL_W'(rsp_data.owner_frames),
                           TOTAL_W'(want.owner_frames));
               check_field("oldest_valid", TOTAL_W'(rsp_data.oldest_valid),
                           TOTAL_W'(want.oldest_valid));
               check_field("oldest_owner", TOTAL_W'(rsp_data.oldest_owner),
                           TOTAL_W'(want.oldest_owner));
               check_field("paged_in_total", rsp_data.paged_in_total,
                           want.paged_in_total);
               check_field("paged_out_total", rsp_data.paged_out_total,
                           want.paged_out_total);
            end
            rsp_index++;
         end
         // predict the response of a request transaction
         if (req_valid && !req_stall)
            pool_rsp_q.insert(pool_rsp_q.size(), apply_pool_request(req_data));
      end
      outstanding <= pool_rsp_q.size();
      fail_count  <= mismatches;
   end

endmodule

// ===== tb/tb_owner_tagged_frame_allocator.sv =====
// top of the frame allocator testbench: clock, reset, directed and random requests
// depends on otfa_pkg, owner_tagged_frame_allocator and otfa_checker
`timescale 1ns / 100ps

module tb_owner_tagged_frame_allocator;
   import otfa_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 425;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_WAIT  = 250;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;

   int           idle_pct;
   int           stall_pct;
   int           cycles = 0;
   logic [7:0]   owner_pool [8];

   owner_tagged_frame_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   otfa_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // response side back-pressure
   always @(posedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_owner_tagged_frame_allocator failed");
         $finish;
      end
   end

   function automatic req_type make_req(input logic [OPCODE_W-1:0] op,
                                        input logic [OWNER_W-1:0] owner,
                                        input logic [FRAMES_W-1:0] wanted);
      req_type r;
      r.opcode        = op;
      r.owner_id      = owner;
      r.frames_wanted = wanted;
      return r;
   endfunction

   // mostly small requests from a few owners so that releases find frames
   function automatic req_type random_request();
      int          roll;
      int          size_roll;
      req_type     r;
      roll      = $urandom_range(99);
      size_roll = $urandom_range(99);
      if (roll < 45)      r.opcode = OP_ALLOC;
      else if (roll < 75) r.opcode = OP_RELEASE;
      else if (roll < 95) r.opcode = OP_STATUS;
      else                r.opcode = OP_UNUSED;
      if ($urandom_range(9) == 0) r.owner_id = OWNER_W'($urandom_range(255));
      else                        r.owner_id = owner_pool[$urandom_range(7)];
      if (size_roll < 70)      r.frames_wanted = FRAMES_W'($urandom_range(6));
      else if (size_roll < 95) r.frames_wanted = FRAMES_W'($urandom_range(20, 7));
      else if (size_roll < 99) r.frames_wanted = FRAMES_W'($urandom_range(64, 21));
      else                     r.frames_wanted = FRAMES_W'($urandom_range(127, 65));
      return r;
   endfunction

   // present one request transaction and hold it until taken
   task automatic send_req(input req_type item);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender holds off until every response is back
   task automatic wait_all_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      idle_pct  = 0;
      stall_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every opcode, whole pool, refusals, empty release, full queue
      send_req(make_req(OP_STATUS, 8'h00, 7'd0));
      send_req(make_req(OP_ALLOC, 8'hFF, 7'd0));
      send_req(make_req(OP_ALLOC, 8'h00, 7'd64));
      send_req(make_req(OP_ALLOC, 8'h01, 7'd1));
      send_req(make_req(OP_RELEASE, 8'h00, 7'd0));
      send_req(make_req(OP_RELEASE, 8'h4D, 7'd0));
      send_req(make_req(OP_RELEASE, 8'h4D, 7'd127));
      send_req(make_req(OP_UNUSED, 8'hAA, 7'h55));
      for (int i = 0; i < 16; i++)
         send_req(make_req(OP_ALLOC, OWNER_W'(i * 17), FRAMES_W'(i % 4)));
      send_req(make_req(OP_ALLOC, 8'h33, 7'd1));
      send_req(make_req(OP_ALLOC, 8'h33, 7'd127));
      wait_all_responses();

      // random phases with different idling on both sides
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 60; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 60; end
            default: begin idle_pct = 26; stall_pct <= 26; end
         endcase
         for (int k = 0; k < 8; k++) owner_pool[k] = OWNER_W'($urandom_range(255));
         for (int n = 0; n < PHASE_ITEMS; n++) send_req(random_request());
         wait_all_responses();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_owner_tagged_frame_allocator passed");
      end else begin
         $display("tb_owner_tagged_frame_allocator failed");
      end
      $finish;
   end

endmodule
